// File: sv/bsp_pkg.sv
// Shared types, widths and constants for the B-spline span and basis evaluator.
// Depends on nothing; every other file imports it.
package bsp_pkg;

   // Field widths of the channels and registers.
   localparam int KNOT_W  = 32;
   localparam int KIDX_W  = 6;
   localparam int SPAN_W  = 6;
   localparam int SLOT_W  = 3;
   localparam int BASIS_W = 17;
   localparam int DEG_W   = 3;
   localparam int LCI_W   = 6;
   localparam int TOL_W   = 8;

   // Internal arithmetic widths.
   localparam int DIFF_W  = KNOT_W + 1;
   localparam int PROD_W  = BASIS_W + 1 + DIFF_W + 1;
   localparam int QCLIP_W = 20;
   localparam int SUM_W   = QCLIP_W + 1;
   localparam int IDX_W   = 8;
   localparam int BND_W   = 7;

   localparam logic [BASIS_W-1:0] BASIS_ONE = 17'd65536;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DEGREE    = 2'd0;
   localparam logic [1:0] REG_LAST_CTRL = 2'd1;
   localparam logic [1:0] REG_SNAP_TOL  = 2'd2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic                     is_eval;
      logic                     wr_ok;
      logic [KIDX_W-1:0]        index;
      logic signed [KNOT_W-1:0] value;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic [SPAN_W-1:0]  span_index;
      logic [SLOT_W-1:0]  basis_slot;
      logic [BASIS_W-1:0] basis_value;
      logic               was_clamped;
      logic               divide_fault;
      logic               last;
   } rsp_item_type;

   // Configuration as the evaluator sees it.
   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic [LCI_W-1:0] last_ctrl;
      logic [TOL_W-1:0] snap_tol;
   } cfg_type;

   // Saturate a signed intermediate to the basis range [0, 1.0].
   function automatic logic [BASIS_W-1:0] sat17(input logic signed [SUM_W-1:0] v);
      logic [BASIS_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SUM_W'(BASIS_ONE))) begin
         r = BASIS_ONE;
      end else begin
         r = v[BASIS_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/bsp_if.sv
// Valid/ready channel interfaces for evaluator requests and results.
// Depends on bsp_pkg for field widths.
interface bsp_req_if;
   import bsp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [KIDX_W-1:0]        knot_index;
   logic signed [KNOT_W-1:0] knot_value;
   logic signed [KNOT_W-1:0] param_u;
   modport source (output valid, operation, knot_index, knot_value, param_u, input ready);
   modport sink (input valid, operation, knot_index, knot_value, param_u, output ready);
endinterface

interface bsp_rsp_if;
   import bsp_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPAN_W-1:0]  span_index;
   logic [SLOT_W-1:0]  basis_slot;
   logic [BASIS_W-1:0] basis_value;
   logic               was_clamped;
   logic               divide_fault;
   logic               last;
   modport source (output valid, span_index, basis_slot, basis_value, was_clamped,
                   divide_fault, last, input ready);
   modport sink (input valid, span_index, basis_slot, basis_value, was_clamped,
                 divide_fault, last, output ready);
endinterface

// File: sv/bsp_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
// Depends on bsp_pkg and bsp_req_if.
module bsp_front #(
   parameter int KNOT_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   bsp_req_if.sink         req_port,
   output logic            q_valid,
   output bsp_pkg::cmd_type q_cmd,
   input  logic            q_pop
);
   import bsp_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd_new;
   logic       push;

   // Classify the incoming item.
   always_comb begin
      cmd_new.is_eval = (op_type'(req_port.operation) == OP_EVAL);
      cmd_new.wr_ok   = (32'(req_port.knot_index) < KNOT_DEPTH);
      cmd_new.index   = req_port.knot_index;
      cmd_new.value   = cmd_new.is_eval ? req_port.param_u : req_port.knot_value;
   end

   assign req_port.ready = (count_ff != 2'd2);
   assign push           = req_port.valid && req_port.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_cmd          = queue_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: sv/bsp_div.sv
// Shared bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on bsp_pkg for operand widths.
module bsp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [bsp_pkg::PROD_W-1:0] num,
   input  logic signed [bsp_pkg::DIFF_W-1:0] den,
   output logic                              done,
   output logic signed [bsp_pkg::PROD_W-1:0] quo
);
   import bsp_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIFF_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DIFF_W:0]   trial;
   logic [DIFF_W:0]   trial_sub;
   logic              fits;

   // One restoring step per cycle.
   always_comb begin
      trial     = {rem_ff, quo_ff[PROD_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
         den_in  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
         neg_in  = num[PROD_W-1] ^ den[DIFF_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

// File: sv/bsp_eval.sv
// Back end: knot memory, span search and Cox-de Boor recurrence sequencer with result register.
// Depends on bsp_pkg and bsp_div.
module bsp_eval #(
   parameter int MAX_DEGREE = 7,
   parameter int KNOT_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsp_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   input  bsp_pkg::cmd_type      q_cmd,
   output logic                  q_pop,
   output bsp_pkg::rsp_item_type rsp_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready
);
   import bsp_pkg::*;

   localparam int KI_W = $clog2(KNOT_DEPTH);
   localparam int BI_W = $clog2(MAX_DEGREE + 1);
   localparam int PC_W = $clog2(KNOT_DEPTH + 1);
   localparam logic signed [PROD_W-1:0] QHI = PROD_W'(262144);
   localparam logic signed [PROD_W-1:0] QLO = -QHI;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_RD_MIN = 15'b000000000000010,
      S_RD_MAX = 15'b000000000000100,
      S_SNAP   = 15'b000000000001000,
      S_PRB_LO = 15'b000000000010000,
      S_PRB_HI = 15'b000000000100000,
      S_TEST   = 15'b000000001000000,
      S_LV_R   = 15'b000000010000000,
      S_LV_L   = 15'b000000100000000,
      S_SUB    = 15'b000001000000000,
      S_MUL    = 15'b000010000000000,
      S_DIVGO  = 15'b000100000000000,
      S_DIV    = 15'b001000000000000,
      S_ACC    = 15'b010000000000000,
      S_EMIT   = 15'b100000000000000
   } state_type;

   // Map a computed knot index onto the table, clamping at both ends.
   function automatic logic [KI_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] x);
      logic [KI_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (int'(x) > KNOT_DEPTH - 1) begin
         r = KI_W'(KNOT_DEPTH - 1);
      end else begin
         r = KI_W'($unsigned(x));
      end
      return r;
   endfunction

   logic signed [KNOT_W-1:0]  knot_mem [KNOT_DEPTH];
   logic signed [KNOT_W-1:0]  rd_data_ff;
   logic [KI_W-1:0]           rd_addr;
   logic                      mem_we;

   state_type                 state_ff, state_in;
   logic signed [KNOT_W-1:0]  u_ff, u_in;
   logic signed [KNOT_W-1:0]  umin_ff, umin_in;
   logic signed [KNOT_W-1:0]  umax_ff, umax_in;
   logic                      clamped_ff, clamped_in;
   logic                      fault_ff, fault_in;
   logic [BND_W-1:0]          lo_ff, lo_in;
   logic [BND_W-1:0]          hi_ff, hi_in;
   logic [BND_W-1:0]          mid_ff, mid_in;
   logic [PC_W-1:0]           probes_ff, probes_in;
   logic [SPAN_W-1:0]         span_ff, span_in;
   logic signed [KNOT_W-1:0]  km_ff, km_in;
   logic signed [KNOT_W-1:0]  r_ff, r_in;
   logic signed [DIFF_W-1:0]  d_ff, d_in;
   logic signed [DIFF_W-1:0]  rmu_ff, rmu_in;
   logic [BASIS_W-1:0]        b_ff, b_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [QCLIP_W-1:0] a_ff, a_in;
   logic                      zero_ff, zero_in;
   logic [BASIS_W-1:0]        carry_ff, carry_in;
   logic [BI_W-1:0]           j_ff, j_in;
   logic [BI_W-1:0]           k_ff, k_in;
   logic [BASIS_W-1:0]        basis_ff [MAX_DEGREE + 1];
   logic [BASIS_W-1:0]        basis_in [MAX_DEGREE + 1];
   rsp_item_type              rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [BI_W-1:0]           p_w;
   logic [BND_W-1:0]          np1;
   logic signed [DIFF_W-1:0]  tol_s;
   logic signed [DIFF_W-1:0]  dmin;
   logic signed [DIFF_W-1:0]  dmax;
   logic signed [KNOT_W-1:0]  u1;
   logic signed [KNOT_W-1:0]  u2;
   logic signed [KNOT_W-1:0]  u3;
   logic [IDX_W-1:0]          ir_u;
   logic [IDX_W-1:0]          il_u;
   logic [IDX_W-1:0]          mid_sum;
   logic [BND_W-1:0]          lo_new;
   logic [BND_W-1:0]          hi_new;
   logic                      lv_go;
   logic [SPAN_W-1:0]         span_sel;
   logic signed [SUM_W-1:0]   acc_sum;
   logic signed [SUM_W-1:0]   acc_rest;
   logic [BASIS_W-1:0]        carry_new;
   logic                      div_start;
   logic                      div_done;
   logic signed [PROD_W-1:0]  div_q;

   // Effective degree and domain bounds from the configuration.
   always_comb begin
      p_w   = (32'(cfg.degree) > MAX_DEGREE) ? BI_W'(MAX_DEGREE) : BI_W'(cfg.degree);
      np1   = BND_W'(cfg.last_ctrl) + 1'b1;
      tol_s = $signed(DIFF_W'(cfg.snap_tol));
      ir_u  = IDX_W'(span_ff) + IDX_W'(k_ff) + 1'b1;
      il_u  = ir_u - IDX_W'(j_ff);
   end

   // Snap to the domain ends, then clamp.
   always_comb begin
      dmin = DIFF_W'(u_ff) - DIFF_W'(umin_ff);
      u1   = (dmin <= tol_s && dmin >= -tol_s) ? umin_ff : u_ff;
      dmax = DIFF_W'(u1) - DIFF_W'(umax_ff);
      u2   = (dmax <= tol_s && dmax >= -tol_s) ? umax_ff : u1;
      if (u2 < umin_ff) begin
         u3 = umin_ff;
      end else if (u2 > umax_ff) begin
         u3 = umax_ff;
      end else begin
         u3 = u2;
      end
   end

   // Knot memory read address for each step.
   always_comb begin
      case (state_ff)
         S_IDLE:   rd_addr = clamp_idx($signed(IDX_W'(p_w)));
         S_RD_MIN: rd_addr = clamp_idx($signed(IDX_W'(np1)));
         S_PRB_LO: rd_addr = clamp_idx($signed(IDX_W'(mid_ff)));
         S_PRB_HI: rd_addr = clamp_idx($signed(IDX_W'(mid_ff) + 1'b1));
         S_LV_R:   rd_addr = clamp_idx($signed(ir_u));
         S_LV_L:   rd_addr = clamp_idx($signed(il_u));
         default:  rd_addr = '0;
      endcase
   end

   assign q_pop  = q_valid && (state_ff == S_IDLE);
   assign mem_we = q_pop && !q_cmd.is_eval && q_cmd.wr_ok;

   // Knot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         knot_mem[KI_W'(q_cmd.index)] <= q_cmd.value;
      end
      rd_data_ff <= knot_mem[rd_addr];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      umin_in      = umin_ff;
      umax_in      = umax_ff;
      clamped_in   = clamped_ff;
      fault_in     = fault_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      probes_in    = probes_ff;
      span_in      = span_ff;
      km_in        = km_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      rmu_in       = rmu_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      a_in         = a_ff;
      zero_in      = zero_ff;
      carry_in     = carry_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      basis_in     = basis_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lv_go        = 1'b0;
      span_sel     = span_ff;
      div_start    = 1'b0;
      lo_new       = lo_ff;
      hi_new       = hi_ff;
      mid_sum      = '0;
      acc_sum      = '0;
      acc_rest     = '0;
      carry_new    = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && q_cmd.is_eval) begin
               u_in     = q_cmd.value;
               fault_in = 1'b0;
               state_in = S_RD_MIN;
            end
         end
         S_RD_MIN: begin
            umin_in  = rd_data_ff;
            state_in = S_RD_MAX;
         end
         S_RD_MAX: begin
            umax_in  = rd_data_ff;
            state_in = S_SNAP;
         end
         S_SNAP: begin
            u_in       = u3;
            clamped_in = (u2 < umin_ff) || (u2 > umax_ff);
            if (u3 == umax_ff) begin
               lv_go    = 1'b1;
               span_sel = SPAN_W'(cfg.last_ctrl);
            end else if (np1 <= BND_W'(p_w)) begin
               lv_go    = 1'b1;
               span_sel = SPAN_W'(p_w);
            end else begin
               mid_sum   = IDX_W'(p_w) + IDX_W'(np1);
               lo_in     = BND_W'(p_w);
               hi_in     = np1;
               mid_in    = mid_sum[IDX_W-1:1];
               probes_in = '0;
               state_in  = S_PRB_LO;
            end
         end
         S_PRB_LO: begin
            state_in = S_PRB_HI;
         end
         S_PRB_HI: begin
            km_in    = rd_data_ff;
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((u_ff < km_ff || u_ff >= rd_data_ff) && probes_ff != PC_W'(KNOT_DEPTH)) begin
               if (u_ff < km_ff) begin
                  hi_new = mid_ff;
               end else begin
                  lo_new = mid_ff;
               end
               mid_sum   = IDX_W'(lo_new) + IDX_W'(hi_new);
               lo_in     = lo_new;
               hi_in     = hi_new;
               mid_in    = mid_sum[IDX_W-1:1];
               probes_in = probes_ff + 1'b1;
               state_in  = S_PRB_LO;
            end else begin
               lv_go    = 1'b1;
               span_sel = SPAN_W'(mid_ff);
            end
         end
         S_LV_R: begin
            state_in = S_LV_L;
         end
         S_LV_L: begin
            r_in     = rd_data_ff;
            state_in = S_SUB;
         end
         S_SUB: begin
            d_in     = DIFF_W'(r_ff) - DIFF_W'(rd_data_ff);
            rmu_in   = DIFF_W'(r_ff) - DIFF_W'(u_ff);
            b_in     = basis_ff[k_ff];
            state_in = S_MUL;
         end
         S_MUL: begin
            // A zero knot interval contributes nothing and raises the fault.
            if (d_ff == 0) begin
               fault_in = 1'b1;
               zero_in  = 1'b1;
               a_in     = '0;
               state_in = S_ACC;
            end else begin
               zero_in  = 1'b0;
               prod_in  = $signed({1'b0, b_ff}) * rmu_ff;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (div_q > QHI) begin
                  a_in = QCLIP_W'(QHI);
               end else if (div_q < QLO) begin
                  a_in = QCLIP_W'(QLO);
               end else begin
                  a_in = QCLIP_W'(div_q);
               end
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_sum     = $signed(SUM_W'(carry_ff)) + SUM_W'(a_ff);
            acc_rest    = zero_ff ? '0 : $signed(SUM_W'(b_ff)) - SUM_W'(a_ff);
            carry_new   = sat17(acc_rest);
            basis_in[k_ff] = sat17(acc_sum);
            if (k_ff + 1'b1 == j_ff) begin
               basis_in[j_ff] = carry_new;
               carry_in       = '0;
               k_in           = '0;
               if (j_ff == p_w) begin
                  j_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_LV_R;
               end
            end else begin
               carry_in = carry_new;
               k_in     = k_ff + 1'b1;
               state_in = S_LV_R;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.span_index   = span_ff;
               rsp_in.basis_slot   = SLOT_W'(j_ff);
               rsp_in.basis_value  = basis_ff[j_ff];
               rsp_in.was_clamped  = clamped_ff;
               rsp_in.divide_fault = fault_ff;
               rsp_in.last         = (j_ff == p_w);
               if (j_ff == p_w) begin
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Start of the recurrence once the span is known.
      if (lv_go) begin
         span_in     = span_sel;
         basis_in[0] = BASIS_ONE;
         carry_in    = '0;
         k_in        = '0;
         if (p_w == '0) begin
            j_in     = '0;
            state_in = S_EMIT;
         end else begin
            j_in     = BI_W'(1);
            state_in = S_LV_R;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      umin_ff    <= umin_in;
      umax_ff    <= umax_in;
      clamped_ff <= clamped_in;
      fault_ff   <= fault_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      probes_ff  <= probes_in;
      span_ff    <= span_in;
      km_ff      <= km_in;
      r_ff       <= r_in;
      d_ff       <= d_in;
      rmu_ff     <= rmu_in;
      b_ff       <= b_in;
      prod_ff    <= prod_in;
      a_ff       <= a_in;
      zero_ff    <= zero_in;
      carry_ff   <= carry_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      basis_ff   <= basis_in;
      rsp_ff     <= rsp_in;
   end

   bsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/bspline_span_and_basis_eval_core.sv
// Top level of the B-spline span finder and basis evaluator.
// Depends on bsp_pkg, bsp_if, bsp_front and bsp_eval.
//
// Use: request items arrive on req_port. Operation 0 writes one knot into the
// table; operation 1 evaluates the basis at param_u and returns degree+1
// result items on rsp_port, one per basis value, the last one marked.
// Registers (APB-style, byte addresses 0, 4, 8): degree, last control point
// index, snap tolerance. Write them only while no evaluation is in flight.
// A two-entry queue parts the front end from the evaluator, so requests are
// taken while an evaluation runs. Items are handled one at a time.
// Sequence: a knot write is done in the evaluator as the item is taken. An
// evaluation reads the domain ends and snaps, runs the search probes, then
// the recurrence steps (degree*(degree+1)/2 steps, a zero knot interval
// skipping the divide), and emits one result per basis value. Each
// recurrence step uses the shared bit-serial divider, which yields
// one quotient bit per cycle over 52 bits.
// Reset clears the queue, the sequencer and the result valid flag, and loads
// degree 3, last index 3 and snap tolerance 0; the knot table holds no reset
// value and must be written before use. When the receiver stalls, the result
// holds on rsp_port and the evaluator waits.
module bspline_span_and_basis_eval_core #(
   parameter int MAX_DEGREE = 7,
   parameter int KNOT_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   bsp_req_if.sink     req_port,
   bsp_rsp_if.source   rsp_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bsp_pkg::*;

   logic [DEG_W-1:0] degree_ff, degree_in;
   logic [LCI_W-1:0] last_ctrl_ff, last_ctrl_in;
   logic [TOL_W-1:0] snap_tol_ff, snap_tol_in;
   logic             cfg_wr;
   cfg_type          cfg;
   logic             q_valid;
   cmd_type          q_cmd;
   logic             q_pop;
   rsp_item_type     rsp_item;
   logic             rsp_valid;

   // Register writes.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      degree_in    = degree_ff;
      last_ctrl_in = last_ctrl_ff;
      snap_tol_in  = snap_tol_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            REG_DEGREE:    degree_in    = pwdata[DEG_W-1:0];
            REG_LAST_CTRL: last_ctrl_in = pwdata[LCI_W-1:0];
            REG_SNAP_TOL:  snap_tol_in  = pwdata[TOL_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= DEG_W'(3);
         last_ctrl_ff <= LCI_W'(3);
         snap_tol_ff  <= '0;
      end else begin
         degree_ff    <= degree_in;
         last_ctrl_ff <= last_ctrl_in;
         snap_tol_ff  <= snap_tol_in;
      end
   end

   // Register reads.
   always_comb begin
      case (paddr[3:2])
         REG_DEGREE:    prdata = 32'(degree_ff);
         REG_LAST_CTRL: prdata = 32'(last_ctrl_ff);
         REG_SNAP_TOL:  prdata = 32'(snap_tol_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg.degree    = degree_ff;
   assign cfg.last_ctrl = last_ctrl_ff;
   assign cfg.snap_tol  = snap_tol_ff;

   bsp_front #(
      .KNOT_DEPTH (KNOT_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   bsp_eval #(
      .MAX_DEGREE (MAX_DEGREE),
      .KNOT_DEPTH (KNOT_DEPTH)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready)
   );

   // Result channel.
   assign rsp_port.valid        = rsp_valid;
   assign rsp_port.span_index   = rsp_item.span_index;
   assign rsp_port.basis_slot   = rsp_item.basis_slot;
   assign rsp_port.basis_value  = rsp_item.basis_value;
   assign rsp_port.was_clamped  = rsp_item.was_clamped;
   assign rsp_port.divide_fault = rsp_item.divide_fault;
   assign rsp_port.last         = rsp_item.last;

endmodule

// File: sv/bsp_checker.sv
// Port-level checks on the result channel of the evaluator, bound to the top level.
// Depends on bsp_pkg for field widths.
module bsp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bsp_pkg::SPAN_W-1:0]  rsp_span_index,
   input logic [bsp_pkg::SLOT_W-1:0]  rsp_basis_slot,
   input logic [bsp_pkg::BASIS_W-1:0] rsp_basis_value,
   input logic                        rsp_last
);
   import bsp_pkg::*;

   // A stalled item stays valid and holds its value, slot, span index and last flag.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_basis_value)
         && $stable(rsp_basis_slot) && $stable(rsp_span_index) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // Basis values never exceed one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_basis_value <= BASIS_ONE)
      else $error("basis value above one");

   // Nothing is offered right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind bspline_span_and_basis_eval_core bsp_checker u_bsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_span_index  (rsp_port.span_index),
   .rsp_basis_slot  (rsp_port.basis_slot),
   .rsp_basis_value (rsp_port.basis_value),
   .rsp_last        (rsp_port.last)
);
